@@ rtl/acp_pkg.sv @@
// Shared types, round constants and the round function of the 320-bit permutation.
// Used by acp_round_stage and ascon_permutation_unit; depends on nothing.
`default_nettype none

package acp_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned NumWords = 5;
  localparam int unsigned RoundsMax = 12;

  typedef logic [NumWords-1:0][WordW-1:0] state_t;
  typedef logic [3:0] round_idx_t;

  // Data carried by one pipeline slot: the state, the schedule position of the
  // round this stage stands for, and the first schedule position that applies.
  typedef struct packed {
    state_t     st;
    round_idx_t pos;
    round_idx_t first;
  } slot_t;

  function automatic logic [7:0] round_const(input round_idx_t idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'hf0;
      4'd1:    c = 8'he1;
      4'd2:    c = 8'hd2;
      4'd3:    c = 8'hc3;
      4'd4:    c = 8'hb4;
      4'd5:    c = 8'ha5;
      4'd6:    c = 8'h96;
      4'd7:    c = 8'h87;
      4'd8:    c = 8'h78;
      4'd9:    c = 8'h69;
      4'd10:   c = 8'h5a;
      4'd11:   c = 8'h4b;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [WordW-1:0] ror64(input logic [WordW-1:0] v, input int unsigned s);
    return (v >> s) | (v << (WordW - s));
  endfunction

  // One full round: constant addition, substitution layer, linear layer.
  function automatic state_t round_f(input state_t s, input logic [7:0] c);
    logic [WordW-1:0] w0, w1, w2, w3, w4;
    logic [WordW-1:0] t0, t1, t2, t3, t4;
    state_t r;
    w0 = s[0];
    w1 = s[1];
    w2 = s[2] ^ {{(WordW-8){1'b0}}, c};
    w3 = s[3];
    w4 = s[4];
    // Substitution layer, one 5-bit S-box per bit slice.
    w0 = w0 ^ w4;
    w4 = w4 ^ w3;
    w2 = w2 ^ w1;
    t0 = ~w0 & w1;
    t1 = ~w1 & w2;
    t2 = ~w2 & w3;
    t3 = ~w3 & w4;
    t4 = ~w4 & w0;
    w0 = w0 ^ t1;
    w1 = w1 ^ t2;
    w2 = w2 ^ t3;
    w3 = w3 ^ t4;
    w4 = w4 ^ t0;
    w1 = w1 ^ w0;
    w0 = w0 ^ w4;
    w3 = w3 ^ w2;
    w2 = ~w2;
    // Linear diffusion layer.
    r[0] = w0 ^ ror64(w0, 19) ^ ror64(w0, 28);
    r[1] = w1 ^ ror64(w1, 61) ^ ror64(w1, 39);
    r[2] = w2 ^ ror64(w2, 1) ^ ror64(w2, 6);
    r[3] = w3 ^ ror64(w3, 10) ^ ror64(w3, 17);
    r[4] = w4 ^ ror64(w4, 7) ^ ror64(w4, 41);
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/acp_round_stage.sv @@
// One pipeline stage of the permutation: a conditional round and a slot register.
// Depends on acp_pkg.
`default_nettype none

module acp_round_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          up_valid,
  output logic               up_ready,
  input  wire acp_pkg::slot_t up_data,
  output logic               dn_valid,
  input  wire logic          dn_ready,
  output acp_pkg::slot_t     dn_data
);

  acp_pkg::slot_t data_next;
  logic           valid;
  acp_pkg::slot_t data;

  // The round applies only once the item has reached its first scheduled round.
  always_comb begin
    data_next       = up_data;
    data_next.pos   = up_data.pos + 4'd1;
    if (up_data.pos >= up_data.first) begin
      data_next.st = acp_pkg::round_f(up_data.st, acp_pkg::round_const(up_data.pos));
    end
  end

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

  assign dn_valid = valid;
  assign dn_data  = data;

endmodule

`default_nettype wire

@@ rtl/ascon_permutation_unit.sv @@
// Top level of the pipelined 320-bit permutation: twelve round stages in a row.
// Depends on acp_pkg and acp_round_stage.
`default_nettype none

// The block takes a request of five 64-bit state words and a round count on the
// req channel and returns the permuted state on the res channel, one result per
// request. Both channels use a valid/ready handshake.
// The rounds taken are the last ones of the twelve-round schedule; a count of zero
// passes the state unchanged and counts above twelve act as twelve.
// Each of the twelve stages holds one round unit and one register. An item walks
// through all twelve stages whatever its round count; a stage whose round lies
// before the item's first scheduled round just passes the state along.
// A request passes through every stage register before res_valid; while res_ready
// is high a new request is accepted in every cycle, so the sustained rate is one
// permutation per cycle. The depth of one round sets the stage delay.
// Each stage is ready when it is empty or its successor is ready, so a stall on
// res_ready fills the pipeline from the back and bubbles are squeezed out; nothing
// is lost or repeated. With the pipeline full and res_ready low, req_ready drops.
// Reset clears every stage's valid bit; the data registers are not reset.
module ascon_permutation_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire logic [63:0] word0_in,
  input  wire logic [63:0] word1_in,
  input  wire logic [63:0] word2_in,
  input  wire logic [63:0] word3_in,
  input  wire logic [63:0] word4_in,
  input  wire logic [3:0]  round_count,
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic [63:0]      word0_out,
  output logic [63:0]      word1_out,
  output logic [63:0]      word2_out,
  output logic [63:0]      word3_out,
  output logic [63:0]      word4_out
);

  localparam int unsigned NumStages = acp_pkg::RoundsMax;

  acp_pkg::slot_t     link_data  [NumStages+1];
  logic               link_valid [NumStages+1];
  logic               link_ready [NumStages+1];
  acp_pkg::round_idx_t rounds_sat;

  // Saturate the round count and turn it into the first schedule position used.
  assign rounds_sat = (round_count > 4'(acp_pkg::RoundsMax)) ?
                      4'(acp_pkg::RoundsMax) : round_count;

  always_comb begin
    link_data[0].st[0] = word0_in;
    link_data[0].st[1] = word1_in;
    link_data[0].st[2] = word2_in;
    link_data[0].st[3] = word3_in;
    link_data[0].st[4] = word4_in;
    link_data[0].pos   = 4'd0;
    link_data[0].first = 4'(acp_pkg::RoundsMax) - rounds_sat;
  end

  assign link_valid[0] = req_valid;
  assign req_ready     = link_ready[0];

  for (genvar g = 0; g < NumStages; g++) begin : g_stage
    acp_round_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .up_valid (link_valid[g]),
      .up_ready (link_ready[g]),
      .up_data  (link_data[g]),
      .dn_valid (link_valid[g+1]),
      .dn_ready (link_ready[g+1]),
      .dn_data  (link_data[g+1])
    );
  end

  // The last stage's register is the output register.
  assign link_ready[NumStages] = res_ready;
  assign res_valid = link_valid[NumStages];
  assign word0_out = link_data[NumStages].st[0];
  assign word1_out = link_data[NumStages].st[1];
  assign word2_out = link_data[NumStages].st[2];
  assign word3_out = link_data[NumStages].st[3];
  assign word4_out = link_data[NumStages].st[4];

endmodule

`default_nettype wire
